/* hw/rtl/domain_name_validator_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the domain name validator
// Shared concurrent assertion forms, clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DOMAIN_NAME_VALIDATOR_TOP_DEFINES_SVH
`define DOMAIN_NAME_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define DNV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DNV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dnv_pkg.sv */
// ----------------------------------------------------------------------------
// dnv_pkg
// Types and constants shared by the domain name validator modules.
// ----------------------------------------------------------------------------
package dnv_pkg;

    // Parse phase codes
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_PREFIX       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_AFTER_PREFIX = 3'd1;
    localparam logic [PHASE_W-1:0] PH_NEED_SLASH   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BODY         = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ESC          = 3'd4;
    localparam logic [PHASE_W-1:0] PH_OCT1         = 3'd5;
    localparam logic [PHASE_W-1:0] PH_OCT2         = 3'd6;

    // Character constants
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam int PREFIX_LEN = 8;

    // One byte transfer as it moves into the parser
    typedef struct packed {
        logic       step;
        logic [7:0] name_byte;
        logic       last_byte;
    } dnv_item_t;

    // Root prefix "<kernel>"
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h3C;   // <
            3'd1: ch = 8'h6B;   // k
            3'd2: ch = 8'h65;   // e
            3'd3: ch = 8'h72;   // r
            3'd4: ch = 8'h6E;   // n
            3'd5: ch = 8'h65;   // e
            3'd6: ch = 8'h6C;   // l
            3'd7: ch = 8'h3E;   // >
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/domain_name_validator_top.sv */
// ----------------------------------------------------------------------------
// domain_name_validator_top
// Byte-serial domain name checker: input register, parser, result register.
// ----------------------------------------------------------------------------
// The last byte passes through the input register and then the result
// register before m_valid rises and the verdict can be taken.
// Throughput: one byte per cycle; the parse state update is one short step.
// A stalled result only holds back the input when the next last byte arrives.
// Reset (aresetn low, synchronous) clears both valid flags and the parse state.
module domain_name_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_name_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted
);

`include "domain_name_validator_top_defines.svh"

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_acc_reg;
    logic       advance;
    logic       verdict;
    dnv_pkg::dnv_item_t item;

    // Held byte moves on unless it is a last byte facing a full result register
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign item.step      = advance;
    assign item.name_byte = in_byte_reg;
    assign item.last_byte = in_last_reg;

    dnv_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .verdict (verdict)
    );

    // Input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) in_valid_next = s_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_name_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_acc_reg <= verdict;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_accepted = out_acc_reg;

    // Checks
    `DNV_ASSERT_NOW(a_ready_low_only_when_held, aclk, aresetn,
        !s_ready, in_valid_reg && in_last_reg && out_valid_reg, "input stalled without cause")
    `DNV_ASSERT_NEXT(a_last_gives_result, aclk, aresetn,
        advance && in_last_reg, m_valid, "verdict missing after last byte")
    `DNV_ASSERT_NEXT(a_held_byte_kept, aclk, aresetn,
        in_valid_reg && !advance, in_valid_reg, "held byte dropped")

endmodule

/* hw/rtl/dnv_parser.sv */
// ----------------------------------------------------------------------------
// dnv_parser
// Holds the parse state and computes the verdict for the byte being stepped.
// ----------------------------------------------------------------------------
module dnv_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  dnv_pkg::dnv_item_t item,
    output logic               verdict
);

    logic [2:0] phase_reg, phase_next, phase_upd;
    logic [3:0] pos_reg, pos_next, pos_upd;
    logic [4:0] oct_reg, oct_next, oct_upd;
    logic       failed_reg, failed_next, failed_upd;

    logic [7:0] c;
    logic [2:0] digit;
    logic       is_oct;
    logic       is_oct_lead;
    logic [7:0] esc_val;

    assign c           = item.name_byte;
    assign digit       = c[2:0];
    assign is_oct      = (c[7:3] == 5'b00110);
    assign is_oct_lead = (c[7:2] == 6'b001100);
    assign esc_val     = {oct_reg, digit};

    // Next state for one byte, taken only while no rule is broken
    always_comb begin
        phase_upd  = phase_reg;
        pos_upd    = pos_reg;
        oct_upd    = oct_reg;
        failed_upd = failed_reg;
        if (!failed_reg) begin
            unique case (phase_reg)
                dnv_pkg::PH_PREFIX: begin
                    if (pos_reg[3] || c != dnv_pkg::prefix_char(pos_reg[2:0])) begin
                        failed_upd = 1'b1;
                    end else begin
                        pos_upd = pos_reg + 4'd1;
                        if (pos_reg == 4'(dnv_pkg::PREFIX_LEN - 1)) begin
                            phase_upd = dnv_pkg::PH_AFTER_PREFIX;
                        end
                    end
                end
                dnv_pkg::PH_AFTER_PREFIX: begin
                    if (c == dnv_pkg::CH_SPACE) phase_upd = dnv_pkg::PH_NEED_SLASH;
                    else failed_upd = 1'b1;
                end
                dnv_pkg::PH_NEED_SLASH: begin
                    if (c == dnv_pkg::CH_SLASH) phase_upd = dnv_pkg::PH_BODY;
                    else failed_upd = 1'b1;
                end
                dnv_pkg::PH_BODY: begin
                    priority if (c == dnv_pkg::CH_SPACE) begin
                        phase_upd = dnv_pkg::PH_NEED_SLASH;
                    end else if (c == dnv_pkg::CH_BSLASH) begin
                        phase_upd = dnv_pkg::PH_ESC;
                    end else if (c < dnv_pkg::CH_SPACE || c >= dnv_pkg::CH_DEL) begin
                        failed_upd = 1'b1;
                    end else begin
                        // plain printable byte stays in the body
                        phase_upd = phase_reg;
                    end
                end
                dnv_pkg::PH_ESC: begin
                    priority if (c == dnv_pkg::CH_BSLASH) begin
                        phase_upd = dnv_pkg::PH_BODY;
                    end else if (is_oct_lead) begin
                        oct_upd   = {3'b000, c[1:0]};
                        phase_upd = dnv_pkg::PH_OCT1;
                    end else begin
                        failed_upd = 1'b1;
                    end
                end
                dnv_pkg::PH_OCT1: begin
                    if (is_oct) begin
                        oct_upd   = {oct_reg[1:0], digit};
                        phase_upd = dnv_pkg::PH_OCT2;
                    end else begin
                        failed_upd = 1'b1;
                    end
                end
                dnv_pkg::PH_OCT2: begin
                    // value must be nonzero and a byte that needs escaping
                    if (is_oct && esc_val != 8'd0 &&
                        (esc_val <= dnv_pkg::CH_SPACE || esc_val >= dnv_pkg::CH_DEL)) begin
                        phase_upd = dnv_pkg::PH_BODY;
                        oct_upd   = 5'd0;
                    end else begin
                        failed_upd = 1'b1;
                    end
                end
                default: failed_upd = 1'b1;
            endcase
        end
    end

    // Verdict from the state after this byte
    assign verdict = !failed_upd &&
                     (phase_upd == dnv_pkg::PH_AFTER_PREFIX || phase_upd == dnv_pkg::PH_BODY);

    // The last byte returns everything to the start of a new name
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        oct_next    = oct_reg;
        failed_next = failed_reg;
        if (item.step) begin
            if (item.last_byte) begin
                phase_next  = dnv_pkg::PH_PREFIX;
                pos_next    = 4'd0;
                oct_next    = 5'd0;
                failed_next = 1'b0;
            end else begin
                phase_next  = phase_upd;
                pos_next    = pos_upd;
                oct_next    = oct_upd;
                failed_next = failed_upd;
            end
        end
    end

    // Parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= dnv_pkg::PH_PREFIX;
            pos_reg    <= 4'd0;
            oct_reg    <= 5'd0;
            failed_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            oct_reg    <= oct_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* tb/domain_name_validator_top_test.sv */
// ----------------------------------------------------------------------------
// domain_name_validator_top_test
// Self-checking bench for the byte-serial domain name checker. A short table
// of directed names runs first, then randomly built names: mostly well-formed
// ones with random components and escapes, plus mutated, cut-short and noise
// names. Every verdict is checked against its table value or an in-bench
// parser model, with bursty input and a patterned, stalling result sink.
// ----------------------------------------------------------------------------
module domain_name_validator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int DRAIN_EVERY   = 450;
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_MAX    = 10;
    localparam int RESET_CYCLES  = 7;

    // Verdict marker for rows whose verdict comes from the parser model
    localparam int VERDICT_PREDICTED = -1;

    localparam logic [63:0] ROOT_TAG   = "<kernel>";
    localparam logic [7:0]  CH_OCT_LO  = 8'h30;  // '0'
    localparam logic [7:0]  CH_OCT_TOP = 8'h33;  // '3'
    localparam logic [7:0]  CH_OCT_HI  = 8'h37;  // '7'

    typedef enum int {NAME_CLEAN, NAME_MUTATED, NAME_CUT, NAME_NOISE} name_kind_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

    typedef struct {
        logic [7:0] name_byte;
        logic       last_byte;
        bit         typed;
        logic       typed_verdict;
    } name_xfer_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_name_byte = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_accepted;

    name_xfer_t     name_stream[$];
    logic [7:0]     draft[$];
    logic           verdict_q[$];
    logic           seen_verdict;
    int             fail_count = 0;
    int             cycle_count = 0;

    // Parser model state
    logic [dnv_pkg::PHASE_W-1:0] parse_ph = dnv_pkg::PH_PREFIX;
    logic [3:0]                  tag_pos = '0;
    logic [4:0]                  oct_acc = '0;
    logic                        name_broken = 1'b0;

    always #5 aclk = ~aclk;

    domain_name_validator_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_name_byte (s_name_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accepted  (m_accepted)
    );

    // Advance the parser model by one byte; returns 1 when a verdict is due
    function automatic bit name_step(input logic [7:0] c, input logic last,
                                     output logic verdict);
        logic [7:0] oct_val;
        verdict = 1'b0;
        if (!name_broken) begin
            case (parse_ph)
                dnv_pkg::PH_PREFIX: begin
                    if (c != ROOT_TAG[63 - 8*tag_pos -: 8]) begin
                        name_broken = 1'b1;
                    end else begin
                        tag_pos = tag_pos + 4'd1;
                        if (tag_pos == dnv_pkg::PREFIX_LEN)
                            parse_ph = dnv_pkg::PH_AFTER_PREFIX;
                    end
                end
                dnv_pkg::PH_AFTER_PREFIX: begin
                    if (c == dnv_pkg::CH_SPACE) parse_ph = dnv_pkg::PH_NEED_SLASH;
                    else name_broken = 1'b1;
                end
                dnv_pkg::PH_NEED_SLASH: begin
                    if (c == dnv_pkg::CH_SLASH) parse_ph = dnv_pkg::PH_BODY;
                    else name_broken = 1'b1;
                end
                dnv_pkg::PH_BODY: begin
                    if (c == dnv_pkg::CH_SPACE) parse_ph = dnv_pkg::PH_NEED_SLASH;
                    else if (c == dnv_pkg::CH_BSLASH) parse_ph = dnv_pkg::PH_ESC;
                    else if (c < dnv_pkg::CH_SPACE || c >= dnv_pkg::CH_DEL) name_broken = 1'b1;
                end
                dnv_pkg::PH_ESC: begin
                    if (c == dnv_pkg::CH_BSLASH) begin
                        parse_ph = dnv_pkg::PH_BODY;
                    end else if (c >= CH_OCT_LO && c <= CH_OCT_TOP) begin
                        oct_acc  = {3'b000, c[1:0]};
                        parse_ph = dnv_pkg::PH_OCT1;
                    end else begin
                        name_broken = 1'b1;
                    end
                end
                dnv_pkg::PH_OCT1: begin
                    if (c >= CH_OCT_LO && c <= CH_OCT_HI) begin
                        oct_acc  = {oct_acc[1:0], c[2:0]};
                        parse_ph = dnv_pkg::PH_OCT2;
                    end else begin
                        name_broken = 1'b1;
                    end
                end
                dnv_pkg::PH_OCT2: begin
                    oct_val = {oct_acc, c[2:0]};
                    // escaped value must be nonzero and a byte that needs escaping
                    if (c >= CH_OCT_LO && c <= CH_OCT_HI && oct_val != 8'h00 &&
                        (oct_val <= dnv_pkg::CH_SPACE || oct_val >= dnv_pkg::CH_DEL)) begin
                        parse_ph = dnv_pkg::PH_BODY;
                        oct_acc  = '0;
                    end else begin
                        name_broken = 1'b1;
                    end
                end
                default: name_broken = 1'b1;
            endcase
        end
        if (!last) return 1'b0;
        verdict = !name_broken &&
                  (parse_ph == dnv_pkg::PH_AFTER_PREFIX || parse_ph == dnv_pkg::PH_BODY);
        parse_ph    = dnv_pkg::PH_PREFIX;
        tag_pos     = '0;
        oct_acc     = '0;
        name_broken = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_text(input string text);
        foreach (text[k]) draft.push_back(text[k]);
    endfunction

    // Move the drafted name into the stream; last byte carries the end mark
    function automatic void commit_draft(input int verdict);
        name_xfer_t x;
        foreach (draft[k]) begin
            x.name_byte     = draft[k];
            x.last_byte     = (k == draft.size() - 1);
            x.typed         = x.last_byte && (verdict != VERDICT_PREDICTED);
            x.typed_verdict = (verdict == 1);
            name_stream.push_back(x);
        end
        draft.delete();
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endfunction

    // Result sink: steps through four stall patterns in turn
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        case (rx_mode_e'((cycle_count / 300) % 4))
            RX_OPEN:    m_ready <= 1'b1;
            RX_COIN:    m_ready <= ($urandom_range(0, 1) == 1);
            RX_PATTERN: m_ready <= ((cycle_count % 9) < 3);
            default:    m_ready <= ($urandom_range(0, 7) == 0);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Verdict checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                note_failure($sformatf("verdict %0b with none expected", m_accepted));
            end else begin
                seen_verdict = verdict_q.pop_front();
                if (m_accepted !== seen_verdict)
                    note_failure($sformatf("verdict mismatch: expected %0b, got %0b",
                                           seen_verdict, m_accepted));
            end
        end
    end

    initial begin
        int         n_directed;
        int         burst_left;
        int         gap;
        int         cut;
        int         pick;
        logic [7:0] b;
        logic [7:0] oct;
        logic [2:0] d1, d2, d3;
        logic       verdict;
        name_kind_e kind;

        // Directed table: bare root, early end in the prefix, bad single bytes,
        // and one octal escape of DEL inside a component
        add_text("<kernel>");        commit_draft(1);
        add_text("<ke");             commit_draft(0);
        draft.push_back(8'hFF);      commit_draft(0);
        draft.push_back(8'h01);      commit_draft(0);
        add_text("<kernel> /\\177"); commit_draft(VERDICT_PREDICTED);
        n_directed = name_stream.size();

        // Random names, mostly well-formed
        while (name_stream.size() < n_directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 6) ? NAME_CLEAN : (pick < 7) ? NAME_MUTATED :
                   (pick < 9) ? NAME_CUT : NAME_NOISE;
            if (kind == NAME_NOISE) begin
                repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(1, 255)));
            end else begin
                add_text("<kernel>");
                repeat ($urandom_range(0, 3)) begin
                    add_text(" /");
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 5))
                            0: add_text("\\\\");
                            1: begin
                                // mostly legal octal escapes, some arbitrary digits
                                if ($urandom_range(0, 3) != 0) begin
                                    oct = ($urandom_range(0, 1) == 1) ?
                                          8'($urandom_range(1, 32)) :
                                          8'($urandom_range(127, 255));
                                    d1 = {1'b0, oct[7:6]};
                                    d2 = oct[5:3];
                                    d3 = oct[2:0];
                                end else begin
                                    d1 = 3'($urandom_range(0, 7));
                                    d2 = 3'($urandom_range(0, 7));
                                    d3 = 3'($urandom_range(0, 7));
                                end
                                draft.push_back(dnv_pkg::CH_BSLASH);
                                draft.push_back(CH_OCT_LO | d1);
                                draft.push_back(CH_OCT_LO | d2);
                                draft.push_back(CH_OCT_LO | d3);
                            end
                            default: begin
                                b = 8'($urandom_range(8'h21, 8'h7E));
                                if (b == dnv_pkg::CH_BSLASH) b = dnv_pkg::CH_SLASH;
                                draft.push_back(b);
                            end
                        endcase
                    end
                end
                if (kind == NAME_MUTATED) begin
                    draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(1, 255));
                end else if (kind == NAME_CUT) begin
                    cut = $urandom_range(1, draft.size());
                    while (draft.size() > cut) void'(draft.pop_back());
                end
            end
            commit_draft(VERDICT_PREDICTED);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender: bursts of transfers with random gaps
        burst_left = 0;
        foreach (name_stream[i]) begin
            if (i == n_directed || (i > 0 && i % DRAIN_EVERY == 0)) begin
                // hold off until every pending verdict is out
                s_valid <= 1'b0;
                @(posedge aclk);
                while (verdict_q.size() != 0) @(posedge aclk);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            s_valid     <= 1'b1;
            s_name_byte <= name_stream[i].name_byte;
            s_last_byte <= name_stream[i].last_byte;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (name_step(name_stream[i].name_byte, name_stream[i].last_byte, verdict))
                verdict_q.push_back(name_stream[i].typed ?
                                    name_stream[i].typed_verdict : verdict);
        end
        s_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dnv_pkg.sv
hw/rtl/dnv_parser.sv
hw/rtl/domain_name_validator_top.sv
tb/domain_name_validator_top_test.sv
